### hw/rtl/llel_pkg.sv
// Shared constants, widths and controller/datapath interface types for the
// lane lateral error limiter. No dependencies.
package llel_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 12;
    localparam int CFG_W     = 13;
    localparam int PT_W      = 14;
    localparam int DIST_W    = 15;
    localparam int ERR_W     = 15;
    localparam int PREV_W    = 16;
    localparam int IDX_W     = 2;

    // Divider and limiter widths
    localparam int DIFF_W = PT_W + 1;
    localparam int MAG_W  = PT_W;
    localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int RAW_W  = NUM_W + 1;
    localparam int CHG_W  = RAW_W + 1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(640);
    localparam logic [CFG_W-1:0] MIN_WIDTH    = CFG_W'(2);

    // Limits: rate limit of 1.0, clamp of 3.0
    localparam logic signed [CHG_W-1:0] CHG_ONE = CHG_W'(1) << FRAC_BITS;
    localparam logic signed [CHG_W-1:0] CHG_LIM = CHG_W'(3) << FRAC_BITS;
    localparam logic signed [ERR_W-1:0] ERR_MAX = ERR_W'(3) << FRAC_BITS;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take a point
        logic start;    // point is the last one: load divider
        logic step;     // one divider iteration
        logic finish;   // rate limit, clamp, register result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

### hw/rtl/lane_lateral_error_limiter_unit.sv
// Top level of the lane lateral error limiter: controller plus datapath.
// Depends on llel_pkg, llel_ctrl, llel_datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_point_x, i_point_y, i_last_point
//  out     | output    | o_out_valid / i_out_stall | o_lateral_error, o_chosen_x
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Points without the last mark may arrive back to back while the input is not stalled.
// A last point loads the restoring divider, which makes one quotient bit per cycle;
// the controller then sees the divider done, and the limiter registers the result.
// The input stalls from the last point until the result is taken.
// Synchronous active-low reset clears control state and restores config values.
// Config writes are always ready.
module lane_lateral_error_limiter_unit
    import llel_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [PT_W-1:0]  i_point_x,
    input  logic signed [PT_W-1:0]  i_point_y,
    input  logic                    i_last_point,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [ERR_W-1:0] o_lateral_error,
    output logic signed [PT_W-1:0]  o_chosen_x,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_cmd    s_cmd;
    t_status s_status;

    assign o_cfg_ready = 1'b1;

    llel_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .i_out_stall  (i_out_stall),
        .i_status     (s_status),
        .o_cmd        (s_cmd),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid)
    );

    llel_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (s_cmd),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .o_status        (s_status),
        .o_lateral_error (o_lateral_error),
        .o_chosen_x      (o_chosen_x)
    );

`ifndef SYNTHESIS
    // A pending result always holds off new points
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input open");

    // A last point starts a frame-end transaction, no result shows at once
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_point) |=> (o_in_stall && !o_out_valid))
        else $error("last point did not start frame end");

    // Emitted error stays within the clamp
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_lateral_error <= ERR_MAX) && (o_lateral_error >= -ERR_MAX)))
        else $error("lateral error out of range");
`endif

endmodule

### hw/rtl/llel_ctrl.sv
// Sequencer for the lateral error limiter: point intake, divide, finish, output.
// Depends on llel_pkg.
module llel_ctrl
    import llel_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_point,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   r_out_valid, n_out_valid;

    // Commands follow the state directly
    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start  = o_cmd.accept && i_last_point;
        o_cmd.step   = (r_state == S_DIV) && !i_status.div_done;
        o_cmd.finish = (r_state == S_FIN);
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_in_stall  = r_in_stall;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state    = S_DIV;
                    n_in_stall = 1'b1;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                    n_in_stall  = 1'b0;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
                n_in_stall  = 1'b0;
            end
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/llel_datapath.sv
// Datapath: config registers, nearest-row tracking, restoring divider,
// rate limiter and clamp, output payload registers. Depends on llel_pkg.
module llel_datapath
    import llel_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  t_cmd                     i_cmd,
    input  logic signed [PT_W-1:0]   i_point_x,
    input  logic signed [PT_W-1:0]   i_point_y,
    output t_status                  o_status,
    output logic signed [ERR_W-1:0]  o_lateral_error,
    output logic signed [PT_W-1:0]   o_chosen_x
);

    logic [CFG_W-1:0]         r_width, r_height;
    logic [DIST_W-1:0]        r_best_dist;
    logic signed [PT_W-1:0]   r_best_x;
    logic                     r_have_point;
    logic signed [PREV_W-1:0] r_prev;

    logic [CFG_W-1:0]         r_div;
    logic [CFG_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_quo;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;

    logic signed [ERR_W-1:0]  r_lat;
    logic signed [PT_W-1:0]   r_cx;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Distance of this point's y from the target row
    logic signed [DIST_W-1:0] s_d;
    logic [DIST_W-1:0]        s_dist;
    logic                     s_take;
    logic signed [PT_W-1:0]   n_best_x;

    always_comb begin
        s_d      = DIST_W'(i_point_y) - $signed({3'b000, r_height[CFG_W-1:1]});
        s_dist   = s_d[DIST_W-1] ? DIST_W'(-s_d) : DIST_W'(s_d);
        s_take   = !r_have_point || (s_dist < r_best_dist);
        n_best_x = s_take ? i_point_x : r_best_x;
    end

    // Divider operands: |best_x - width/2| << (FRAC+1), divisor max(width, 2)
    logic signed [DIFF_W-1:0] s_diff;
    logic [DIFF_W-1:0]        s_abs;
    logic [CFG_W-1:0]         s_w;

    always_comb begin
        s_diff = DIFF_W'(n_best_x) - $signed({3'b000, r_width[CFG_W-1:1]});
        s_abs  = s_diff[DIFF_W-1] ? DIFF_W'(-s_diff) : DIFF_W'(s_diff);
        s_w    = (r_width < MIN_WIDTH) ? MIN_WIDTH : r_width;
    end

    // One restoring division step
    logic [CFG_W:0]   s_shift;
    logic [CFG_W:0]   s_sub;
    logic             s_ge;

    always_comb begin
        s_shift = {r_rem, r_quo[NUM_W-1]};
        s_sub   = s_shift - {1'b0, r_div};
        s_ge    = (s_shift >= {1'b0, r_div});
    end

    // Rate limit and clamp against the previous error
    logic signed [RAW_W-1:0] s_raw;
    logic signed [CHG_W-1:0] s_prev;
    logic signed [CHG_W-1:0] s_chg;
    logic signed [CHG_W-1:0] s_chg_c;
    logic signed [CHG_W-1:0] s_lat;
    logic signed [CHG_W-1:0] s_lat_c;

    always_comb begin
        s_raw  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        s_prev = CHG_W'(r_prev);
        s_chg  = CHG_W'(s_raw) - s_prev;
        if (s_chg > CHG_ONE) begin
            s_chg_c = CHG_ONE;
        end else if (s_chg < -CHG_ONE) begin
            s_chg_c = -CHG_ONE;
        end else begin
            s_chg_c = s_chg;
        end
        s_lat = s_prev + s_chg_c;
        if (s_lat > CHG_LIM) begin
            s_lat_c = CHG_LIM;
        end else if (s_lat < -CHG_LIM) begin
            s_lat_c = -CHG_LIM;
        end else begin
            s_lat_c = s_lat;
        end
    end

    // Tracking state and previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist  <= '0;
            r_best_x     <= '0;
            r_have_point <= 1'b0;
            r_prev       <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_cmd.start) begin
                    r_have_point <= 1'b0;
                    r_best_dist  <= '0;
                    r_cnt        <= CNT_W'(NUM_W);
                end else begin
                    r_have_point <= 1'b1;
                    if (s_take) begin
                        r_best_dist <= s_dist;
                    end
                end
                r_best_x <= n_best_x;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_prev <= s_lat_c[PREV_W-1:0];
            end
        end
    end

    // Divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_div <= s_w;
            r_rem <= '0;
            r_quo <= {s_abs[MAG_W-1:0], {(FRAC_BITS + 1){1'b0}}};
            r_neg <= s_diff[DIFF_W-1];
            r_cx  <= n_best_x;
        end else if (i_cmd.step) begin
            r_rem <= s_ge ? s_sub[CFG_W-1:0] : s_shift[CFG_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], s_ge};
        end
        if (i_cmd.finish) begin
            r_lat <= s_lat_c[ERR_W-1:0];
        end
    end

    assign o_status.div_done = (r_cnt == '0);
    assign o_lateral_error   = r_lat;
    assign o_chosen_x        = r_cx;

endmodule
